[hw/rtl/binary_to_decimal_ascii_top_macros.svh]
// Assertion macros used by the RTL of the decimal text converter.
`ifndef BINARY_TO_DECIMAL_ASCII_TOP_MACROS_SVH
`define BINARY_TO_DECIMAL_ASCII_TOP_MACROS_SVH

// Same-cycle implication, checked on the rising clock edge outside reset.
`define B2DA_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("same-cycle check failed");

// Next-cycle implication, checked on the rising clock edge outside reset.
`define B2DA_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("next-cycle check failed");

`endif

[hw/rtl/b2da_pkg.sv]
package b2da_pkg;

   localparam int unsigned VALUE_WIDTH    = 32;
   localparam int unsigned DIGIT_COUNT    = 10;
   localparam int unsigned DIGIT_WIDTH    = 4;
   localparam int unsigned BCD_WIDTH      = DIGIT_COUNT * DIGIT_WIDTH;
   localparam int unsigned STAGE_COUNT    = 4;
   localparam int unsigned BITS_PER_STAGE = VALUE_WIDTH / STAGE_COUNT;
   localparam int unsigned COUNT_WIDTH    = 4;
   localparam int unsigned CHAR_WIDTH     = 8;

   localparam logic [CHAR_WIDTH-1:0]  CHAR_SPACE    = 8'h20;
   localparam logic [CHAR_WIDTH-1:0]  CHAR_ZERO     = 8'h30;
   localparam logic [COUNT_WIDTH-1:0] LAST_POSITION = 4'd9;

   typedef logic [BCD_WIDTH-1:0]      bcd_type;
   typedef logic [VALUE_WIDTH-1:0]    value_type;
   typedef logic [BITS_PER_STAGE-1:0] slice_type;
   typedef logic [DIGIT_WIDTH-1:0]    digit_type;

   // Shift-and-add-three over one slice of the binary value, most significant bit first.
   function automatic bcd_type dabble_slice(bcd_type bcd_i, slice_type bits_i);
      bcd_type   acc;
      digit_type d;
      acc = bcd_i;
      for (int step = 0; step < BITS_PER_STAGE; step++) begin
         for (int k = 0; k < DIGIT_COUNT; k++) begin
            d = acc[k*DIGIT_WIDTH +: DIGIT_WIDTH];
            if (d >= 4'd5) begin
               acc[k*DIGIT_WIDTH +: DIGIT_WIDTH] = d + 4'd3;
            end
         end
         acc = {acc[BCD_WIDTH-2:0], bits_i[BITS_PER_STAGE-1-step]};
      end
      return acc;
   endfunction

endpackage

[hw/rtl/binary_to_decimal_ascii_top.sv]
// Converts a 32-bit unsigned value to ten right-aligned decimal ASCII characters.
// A value passes the four conversion stage registers and the serializer register before
// its first character is strobed. The one-character-per-cycle result port sets the pace;
// four conversion stages of eight shift-and-add-three steps each buffer values meanwhile.
// Reset (synchronous, active high) empties the pipeline and the character serializer.
// The receiver cannot stall; busy is high only while the first conversion stage is blocked.
`include "binary_to_decimal_ascii_top_macros.svh"

module binary_to_decimal_ascii_top (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   output logic                                busy,
   input  logic [b2da_pkg::VALUE_WIDTH-1:0]    req_value,
   output logic                                rsp_strobe,
   output logic [b2da_pkg::CHAR_WIDTH-1:0]     rsp_character,
   output logic                                rsp_last
);

   localparam int unsigned NS = b2da_pkg::STAGE_COUNT;
   localparam int unsigned BW = b2da_pkg::BITS_PER_STAGE;
   localparam int unsigned VW = b2da_pkg::VALUE_WIDTH;

   logic                   valid_ff [NS];
   logic                   valid_in [NS];
   b2da_pkg::bcd_type      bcd_ff   [NS];
   b2da_pkg::bcd_type      bcd_in   [NS];
   b2da_pkg::value_type    value_ff [NS];
   b2da_pkg::value_type    value_in [NS];
   logic                   stage_ready [NS];

   b2da_pkg::bcd_type                  digits_ff, digits_in;
   logic [b2da_pkg::COUNT_WIDTH-1:0]   count_ff, count_in;
   logic                               active_ff, active_in;
   logic                               seen_ff, seen_in;

   logic                   accept;
   logic                   load;
   b2da_pkg::digit_type    cur_digit;
   logic                   blank;

   assign busy   = !stage_ready[0];
   assign accept = start && !busy;
   assign load   = valid_ff[NS-1] && stage_ready[NS-1];

   // A stage may take new data when it is empty or its contents move on this cycle.
   always_comb begin
      stage_ready[NS-1] = !valid_ff[NS-1] || !active_ff ||
                          (count_ff == b2da_pkg::LAST_POSITION);
      for (int s = NS - 2; s >= 0; s--) begin
         stage_ready[s] = !valid_ff[s] || stage_ready[s+1];
      end
   end

   always_comb begin
      for (int s = 0; s < NS; s++) begin
         if (s == 0) begin
            valid_in[s] = accept;
            value_in[s] = req_value;
            bcd_in[s]   = b2da_pkg::dabble_slice('0, req_value[VW-1 -: BW]);
         end else begin
            valid_in[s] = valid_ff[s-1];
            value_in[s] = value_ff[s-1];
            bcd_in[s]   = b2da_pkg::dabble_slice(bcd_ff[s-1],
                                                 value_ff[s-1][VW-1-BW*s -: BW]);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int s = 0; s < NS; s++) begin
            valid_ff[s] <= 1'b0;
         end
      end else begin
         for (int s = 0; s < NS; s++) begin
            if (stage_ready[s]) begin
               valid_ff[s] <= valid_in[s];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int s = 0; s < NS; s++) begin
         if (stage_ready[s]) begin
            value_ff[s] <= value_in[s];
            bcd_ff[s]   <= bcd_in[s];
         end
      end
   end

   // Serializer: the top digit of digits_ff is the character on the port this cycle.
   assign cur_digit = digits_ff[b2da_pkg::BCD_WIDTH-1 -: b2da_pkg::DIGIT_WIDTH];
   assign blank     = !seen_ff && (cur_digit == '0) &&
                      (count_ff != b2da_pkg::LAST_POSITION);

   always_comb begin
      digits_in = digits_ff;
      count_in  = count_ff;
      seen_in   = seen_ff;
      active_in = active_ff;
      if (load) begin
         digits_in = bcd_ff[NS-1];
         count_in  = '0;
         seen_in   = 1'b0;
         active_in = 1'b1;
      end else if (active_ff) begin
         digits_in = {digits_ff[b2da_pkg::BCD_WIDTH-b2da_pkg::DIGIT_WIDTH-1:0],
                      {b2da_pkg::DIGIT_WIDTH{1'b0}}};
         seen_in   = seen_ff || (cur_digit != '0);
         if (count_ff == b2da_pkg::LAST_POSITION) begin
            active_in = 1'b0;
         end else begin
            count_in = count_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
         count_ff  <= '0;
      end else begin
         active_ff <= active_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      digits_ff <= digits_in;
      seen_ff   <= seen_in;
   end

   assign rsp_strobe    = active_ff;
   assign rsp_last      = active_ff && (count_ff == b2da_pkg::LAST_POSITION);
   assign rsp_character = blank ? b2da_pkg::CHAR_SPACE
                                : (b2da_pkg::CHAR_ZERO |
                                   {{(b2da_pkg::CHAR_WIDTH-b2da_pkg::DIGIT_WIDTH){1'b0}},
                                    cur_digit});

   // The ten characters of one value are strobed on consecutive cycles.
   `B2DA_ASSERT_NEXT(a_chars_contiguous, clock, reset, rsp_strobe && !rsp_last, rsp_strobe)
   // Once a digit has been shown, no padding space follows within the same value.
   `B2DA_ASSERT_NEXT(a_no_space_after_digit, clock, reset,
      rsp_strobe && !rsp_last && (rsp_character != b2da_pkg::CHAR_SPACE),
      rsp_character != b2da_pkg::CHAR_SPACE)
   // Busy means the first stage holds a value that cannot move on.
   `B2DA_ASSERT_SAME(a_busy_holds_item, clock, reset, busy, valid_ff[0] && !stage_ready[1])
   // A value in the last stage stays there until the serializer takes it.
   `B2DA_ASSERT_NEXT(a_last_stage_held, clock, reset,
      valid_ff[NS-1] && !load, valid_ff[NS-1] && $stable(bcd_ff[NS-1]))

endmodule

[dv/binary_to_decimal_ascii_top_tb.sv]
module binary_to_decimal_ascii_top_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int unsigned CYCLE_LIMIT    = 200000;
   localparam int unsigned RANDOM_VALUES  = 360;
   localparam int unsigned SETTLE_CYCLES  = 20;
   localparam int unsigned MAX_REPORTED   = 10;

   typedef struct {
      logic [b2da_pkg::CHAR_WIDTH-1:0] character;
      logic                            last;
   } text_char_type;

   logic                             clock = 1'b0;
   logic                             reset = 1'b1;
   logic                             start = 1'b0;
   logic                             busy;
   logic [b2da_pkg::VALUE_WIDTH-1:0] req_value = '0;
   logic                             rsp_strobe;
   logic [b2da_pkg::CHAR_WIDTH-1:0]  rsp_character;
   logic                             rsp_last;

   text_char_type pending_text[$];
   int unsigned   mismatch_count = 0;
   int unsigned   cycle_count = 0;

   binary_to_decimal_ascii_top uut (
      .clock         (clock),
      .reset         (reset),
      .start         (start),
      .busy          (busy),
      .req_value     (req_value),
      .rsp_strobe    (rsp_strobe),
      .rsp_character (rsp_character),
      .rsp_last      (rsp_last)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("[binary_to_decimal_ascii_top] ERROR");
         $finish;
      end
   end

   // Right-aligned decimal text: spaces above the leading digit, units always a digit.
   function automatic void queue_decimal_text(input logic [b2da_pkg::VALUE_WIDTH-1:0] value);
      logic [b2da_pkg::VALUE_WIDTH-1:0] rest;
      logic [b2da_pkg::CHAR_WIDTH-1:0]  text [b2da_pkg::DIGIT_COUNT];
      text_char_type                    entry;
      rest = value;
      for (int slot = b2da_pkg::DIGIT_COUNT - 1; slot >= 0; slot--) begin
         if (rest == '0 && slot < b2da_pkg::DIGIT_COUNT - 1) begin
            text[slot] = b2da_pkg::CHAR_SPACE;
         end else begin
            text[slot] = b2da_pkg::CHAR_ZERO + b2da_pkg::CHAR_WIDTH'(rest % 10);
         end
         rest = rest / 10;
      end
      for (int pos = 0; pos < b2da_pkg::DIGIT_COUNT; pos++) begin
         entry.character = text[pos];
         entry.last      = (pos == b2da_pkg::DIGIT_COUNT - 1);
         pending_text.push_back(entry);
      end
   endfunction

   task automatic note_mismatch(input string what, input text_char_type want);
      mismatch_count++;
      if (mismatch_count <= MAX_REPORTED) begin
         $display("mismatch (%s): expected char %h last %b, got char %h last %b",
                  what, want.character, want.last, rsp_character, rsp_last);
      end
   endtask

   always @(posedge clock) begin
      text_char_type want;
      if (!reset && rsp_strobe) begin
         if (pending_text.size() == 0) begin
            want.character = 'x;
            want.last      = 'x;
            note_mismatch("unexpected character", want);
         end else begin
            want = pending_text.pop_front();
            if (rsp_character !== want.character || rsp_last !== want.last) begin
               note_mismatch("character transfer", want);
            end
         end
      end
   end

   // Leaves start high so that a following call makes a back-to-back transfer.
   task automatic send_value(input logic [b2da_pkg::VALUE_WIDTH-1:0] value);
      start     <= 1'b1;
      req_value <= value;
      do begin
         @(posedge clock);
      end while (busy);
      queue_decimal_text(value);
   endtask

   task automatic hold_off(input int unsigned cycles);
      start <= 1'b0;
      repeat (cycles) begin
         req_value <= $urandom;
         @(posedge clock);
      end
   endtask

   task automatic wait_for_text_drained();
      while (pending_text.size() != 0) begin
         @(posedge clock);
      end
   endtask

   function automatic logic [b2da_pkg::VALUE_WIDTH-1:0] random_by_digit_count();
      longint unsigned low;
      longint unsigned high;
      int unsigned     digits;
      digits = $urandom_range(1, b2da_pkg::DIGIT_COUNT);
      low    = 1;
      for (int i = 1; i < digits; i++) begin
         low = low * 10;
      end
      high = low * 10 - 1;
      if (digits == 1) begin
         low = 0;
      end
      if (high > 64'hFFFF_FFFF) begin
         high = 64'hFFFF_FFFF;
      end
      return b2da_pkg::VALUE_WIDTH'(low + longint'({$urandom}) % (high - low + 1));
   endfunction

   task automatic test_directed_values();
      logic [b2da_pkg::VALUE_WIDTH-1:0] values [$];
      values = {32'd0, 32'd1, 32'd9, 32'd10, 32'd99, 32'd100, 32'd9999, 32'd100000,
                32'd999999999, 32'd1000000000, 32'hFFFF_FFFF, 32'hFFFF_FFFE,
                32'h8000_0000, 32'h7FFF_FFFF, 32'h5555_5555, 32'hAAAA_AAAA};
      foreach (values[i]) begin
         send_value(values[i]);
         if (i % 4 == 3) begin
            hold_off($urandom_range(1, 12));
         end
      end
      hold_off(3);
   endtask

   // The sender stops until every character of the earlier values has come out.
   task automatic test_pause_until_drained();
      repeat (3) begin
         send_value($urandom);
      end
      hold_off(1);
      wait_for_text_drained();
      send_value(32'd0);
      send_value(32'hFFFF_FFFF);
      hold_off(2);
   endtask

   task automatic test_random_values();
      int unsigned sent;
      int unsigned burst;
      int unsigned kind;
      logic [b2da_pkg::VALUE_WIDTH-1:0] value;
      sent = 0;
      while (sent < RANDOM_VALUES) begin
         burst = $urandom_range(1, 12);
         repeat (burst) begin
            kind = $urandom_range(0, 9);
            if (kind < 4) begin
               value = $urandom;
            end else if (kind < 8) begin
               value = random_by_digit_count();
            end else begin
               value = $urandom_range(0, 20);
            end
            send_value(value);
            sent++;
         end
         // Some bursts run straight into the next one with no gap at all.
         if ($urandom_range(0, 3) != 0) begin
            hold_off($urandom_range(1, 25));
         end
      end
      hold_off(1);
   endtask

   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_directed_values();
      test_pause_until_drained();
      test_random_values();

      wait_for_text_drained();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (mismatch_count == 0 && pending_text.size() == 0) begin
         $display("[binary_to_decimal_ascii_top] OK");
      end else begin
         $display("[binary_to_decimal_ascii_top] ERROR");
      end
      $finish;
   end

endmodule
